FILE: src/max_heap_priority_queue_macros.svh
// Assertion helpers for the heap queue; all checks sample on clk_i and
// are disabled while rst_ni is low.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  localparam int unsigned KEY_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

FILE: src/max_heap_priority_queue.sv
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+---------------------------------------------
// in      | input     | in_valid_i/in_ready_o | kind_i, value_i
// out     | output    | out_valid_o/out_ready_i | status_o, removed_value_o, top_valid_o,
//         |           |                       | top_value_o, entry_count_o
//
// One transaction at a time.
// Insert: the key climbs past strictly smaller parents, then is written into its slot.
// Remove: returns the root; unless that empties the heap, the last entry refills the root
//   and sinks toward the larger child. Clear, refused and unused kinds go straight to finish.
// Reset clears the count, the state and out_valid_o only; memory slots at or above the count are never read.
// in_ready_o is high whenever the engine is idle; finish holds while a result waits on out.
`default_nettype none

`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      kind_i,
  input  wire logic signed [KEY_W-1:0]         value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic signed [KEY_W-1:0]              removed_value_o,
  output logic                                 top_valid_o,
  output logic signed [KEY_W-1:0]              top_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]        entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Child index width: 2*pos+2 must fit.
  localparam int unsigned IW = AW + 2;

  // Heap storage with a registered (synchronous) read.
  logic signed [KEY_W-1:0] mem_q [CAPACITY];
  logic signed [KEY_W-1:0] rdata_q;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] lv_q, lv_d;
  logic signed [KEY_W-1:0] root_q, root_d;
  status_e                 status_q, status_d;
  logic signed [KEY_W-1:0] removed_q, removed_d;

  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q, out_status_d;
  logic signed [KEY_W-1:0] out_removed_q, out_removed_d;
  logic                    out_top_valid_q, out_top_valid_d;
  logic signed [KEY_W-1:0] out_top_q, out_top_d;
  logic [CW-1:0]           out_count_q, out_count_d;

  logic                    in_fire;
  logic [CW-1:0]           last_idx;
  logic [AW-1:0]           parent;
  logic [IW-1:0]           l_idx, r_idx, cnt_ext;
  logic                    r_ok, take_r;
  logic signed [KEY_W-1:0] child_v;
  logic [IW-1:0]           child_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign last_idx  = count_q - CW'(1);
  assign parent    = (pos_q - AW'(1)) >> 1;
  assign l_idx     = {1'b0, pos_q, 1'b1};
  assign r_idx     = l_idx + IW'(1);
  assign cnt_ext   = IW'(count_q);
  assign r_ok      = (r_idx < cnt_ext);
  // Right child wins only when strictly greater; ties go left.
  assign take_r    = r_ok && (rdata_q > lv_q);
  assign child_v   = take_r ? rdata_q : lv_q;
  assign child_idx = take_r ? r_idx : l_idx;

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    pos_d           = pos_q;
    key_d           = key_q;
    lv_d            = lv_q;
    status_d        = status_q;
    removed_d       = removed_q;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = pos_q;
    wr_data         = key_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_status_d    = out_status_q;
    out_removed_d   = out_removed_q;
    out_top_valid_d = out_top_valid_q;
    out_top_d       = out_top_q;
    out_count_d     = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d  = ST_DONE;
          removed_d = '0;
          state_d   = S_FIN;
          unique case (kind_i)
            KIND_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                key_d   = value_i;
                pos_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            KIND_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                removed_d = root_q;
                count_d   = last_idx;
                // Fetch the last entry; it refills the root.
                rd_en     = 1'b1;
                rd_addr   = last_idx[AW-1:0];
                if (last_idx != '0) begin
                  state_d = S_DN_LAST;
                end
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (key_q > rdata_q) begin
          // Pull the parent down into the hole and climb.
          wr_data = rdata_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      S_DN_LAST: begin
        key_d   = rdata_q;
        pos_d   = '0;
        state_d = S_DN_L;
      end

      S_DN_L: begin
        if (l_idx >= cnt_ext) begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = l_idx[AW-1:0];
          state_d = S_DN_R;
        end
      end

      S_DN_R: begin
        lv_d = rdata_q;
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = r_idx[AW-1:0];
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        if (child_v > key_q) begin
          // Lift the larger child into the hole and descend.
          wr_data = child_v;
          pos_d   = child_idx[AW-1:0];
          state_d = S_DN_L;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_status_d    = status_q;
          out_removed_d   = removed_q;
          out_top_valid_d = (count_q != '0);
          out_top_d       = (count_q != '0) ? root_q : '0;
          out_count_d     = count_q;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Shadow the root so the top is available without a memory read.
  always_comb begin
    root_d = root_q;
    if (wr_en && (wr_addr == '0)) begin
      root_d = wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q           <= pos_d;
    key_q           <= key_d;
    lv_q            <= lv_d;
    root_q          <= root_d;
    status_q        <= status_d;
    removed_q       <= removed_d;
    out_status_q    <= out_status_d;
    out_removed_q   <= out_removed_d;
    out_top_valid_q <= out_top_valid_d;
    out_top_q       <= out_top_d;
    out_count_q     <= out_count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign top_valid_o     = out_top_valid_q;
  assign top_value_o     = out_top_q;
  assign entry_count_o   = out_count_q;

  `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY),
                   "entry count overflow")
  `MHPQ_ASSERT_NEXT(a_remove_dec,
                    in_fire && (kind_i == KIND_REMOVE) && (count_q != '0),
                    count_q == $past(count_q) - CW'(1), "remove did not drop count")
  `MHPQ_ASSERT_NOW(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN,
                   "result loaded outside finish")
  `MHPQ_ASSERT_NEXT(a_root_shadow, wr_en && (wr_addr == '0), root_q == $past(wr_data),
                    "root shadow stale")
  `MHPQ_ASSERT_NOW(a_top_count, out_valid_q, out_top_valid_q == (out_count_q != '0),
                   "top valid mismatch")

endmodule

`default_nettype wire

FILE: tb/tb_max_heap_priority_queue.sv
`timescale 1ns / 100ps

module tb_max_heap_priority_queue
  import mhpq_pkg::*;
;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // The block has no name for the fourth command code; it must be a no-op.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_NEG1 = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 32;    // longer than the slowest remove
  localparam int CALM_FROM = 350;     // no random idling on either side in this window
  localparam int CALM_TO = 500;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] removed;
    logic             top_valid;
    logic [KEY_W-1:0] top;
    logic [CNT_W-1:0] entries;
  } heap_result_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic             typed;  // use want instead of the predictor
    heap_result_t     want;
  } stim_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  localparam heap_result_t NO_CHECK = '0;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              kind_i = KIND_INSERT;
  logic signed [KEY_W-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              status_o;
  logic signed [KEY_W-1:0] removed_value_o;
  logic                    top_valid_o;
  logic signed [KEY_W-1:0] top_value_o;
  logic [CNT_W-1:0]        entry_count_o;

  max_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .top_valid_o    (top_valid_o),
    .top_value_o    (top_value_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Heap mirror: same layout as the block, root in slot 0.
  logic signed [KEY_W-1:0] model_keys [CAPACITY];
  int                      model_size = 0;

  heap_result_t expected_results [$];
  int           commands_sent = 0;
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  logic         calm;

  assign calm = (commands_sent >= CALM_FROM) && (commands_sent < CALM_TO);

  // Directed opening: empty-heap refusals, the no-op code, both key extremes,
  // equal keys on both sift paths, clear, and a single-entry round trip.
  // Only rows whose outcome is obvious carry a typed result.
  stim_row_t directed_rows [23] = '{
    '{KIND_REMOVE, 32'h0000_0000, 1'b1, '{ST_EMPTY, '0, 1'b0, '0, '0}},
    '{KIND_SPARE,  KEY_NEG1,      1'b1, '{ST_DONE, '0, 1'b0, '0, '0}},
    '{KIND_CLEAR,  32'h0F0F_0F0F, 1'b1, '{ST_DONE, '0, 1'b0, '0, '0}},
    '{KIND_INSERT, KEY_MIN,       1'b1, '{ST_DONE, '0, 1'b1, KEY_MIN, 7'd1}},
    '{KIND_INSERT, KEY_MAX,       1'b1, '{ST_DONE, '0, 1'b1, KEY_MAX, 7'd2}},
    '{KIND_INSERT, 32'h0000_0000, 1'b0, NO_CHECK},
    '{KIND_INSERT, KEY_NEG1,      1'b0, NO_CHECK},
    '{KIND_INSERT, KEY_MAX,       1'b0, NO_CHECK},
    '{KIND_INSERT, 32'h0000_0005, 1'b0, NO_CHECK},
    '{KIND_INSERT, 32'h0000_0005, 1'b0, NO_CHECK},
    '{KIND_SPARE,  32'h1234_5678, 1'b0, NO_CHECK},
    '{KIND_REMOVE, 32'hFFFF_0000, 1'b1, '{ST_DONE, KEY_MAX, 1'b1, KEY_MAX, 7'd6}},
    '{KIND_REMOVE, 32'h0000_FFFF, 1'b1, '{ST_DONE, KEY_MAX, 1'b1, 32'd5, 7'd5}},
    '{KIND_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
    '{KIND_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
    '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, NO_CHECK},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, NO_CHECK},
    '{KIND_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
    '{KIND_CLEAR,  32'hF0F0_F0F0, 1'b1, '{ST_DONE, '0, 1'b0, '0, '0}},
    '{KIND_REMOVE, 32'h0000_0000, 1'b1, '{ST_EMPTY, '0, 1'b0, '0, '0}},
    '{KIND_INSERT, KEY_NEG1,      1'b1, '{ST_DONE, '0, 1'b1, KEY_NEG1, 7'd1}},
    '{KIND_REMOVE, 32'h0000_0000, 1'b1, '{ST_DONE, KEY_NEG1, 1'b0, '0, '0}},
    '{KIND_REMOVE, 32'h0000_0000, 1'b1, '{ST_EMPTY, '0, 1'b0, '0, '0}}
  };

  // Advance the heap mirror by one command and return the result it owes.
  function automatic heap_result_t heap_apply(input logic [1:0] kind,
                                              input logic [KEY_W-1:0] key);
    heap_result_t            res;
    int                      pos;
    int                      parent;
    int                      child;
    int                      best;
    bit                      moving;
    logic signed [KEY_W-1:0] tmp;
    res = '0;
    res.status = ST_DONE;
    case (kind)
      KIND_INSERT: begin
        if (model_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // Climb only past a strictly smaller parent.
          pos = model_size;
          model_keys[pos] = key;
          model_size++;
          moving = 1'b1;
          while (moving && pos > 0) begin
            parent = (pos - 1) / 2;
            if (model_keys[pos] > model_keys[parent]) begin
              tmp = model_keys[pos];
              model_keys[pos] = model_keys[parent];
              model_keys[parent] = tmp;
              pos = parent;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (model_size == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed = model_keys[0];
          model_size--;
          model_keys[0] = model_keys[model_size];
          // Descend toward the larger child; the left one wins a tie.
          pos = 0;
          moving = 1'b1;
          while (moving) begin
            child = 2 * pos + 1;
            best = pos;
            if (child < model_size && model_keys[child] > model_keys[best]) begin
              best = child;
            end
            if (child + 1 < model_size && model_keys[child + 1] > model_keys[best]) begin
              best = child + 1;
            end
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              tmp = model_keys[pos];
              model_keys[pos] = model_keys[best];
              model_keys[best] = tmp;
              pos = best;
            end
          end
        end
      end
      KIND_CLEAR: begin
        model_size = 0;
      end
      default: begin
      end
    endcase
    res.top_valid = (model_size > 0);
    res.top = (model_size > 0) ? model_keys[0] : '0;
    res.entries = CNT_W'(model_size);
    return res;
  endfunction

  // Favor a few small keys (lots of ties) and keys near both extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return KEY_MIN + $urandom_range(3);
      1:       return KEY_MAX - $urandom_range(3);
      2, 3, 4: return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_kind(input mix_e mix);
    int roll;
    int insert_pct;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  insert_pct = 85;
      MIX_DRAIN: insert_pct = 18;
      default:   insert_pct = 52;
    endcase
    if (roll < 2) return KIND_SPARE;
    if (roll < 3) return KIND_CLEAR;
    if (roll < 3 + (insert_pct * 97) / 100) return KIND_INSERT;
    return KIND_REMOVE;
  endfunction

  // Present one transaction, hold it until taken, then record what it owes.
  task automatic push_command(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                              input logic typed, input heap_result_t want);
    heap_result_t predicted;
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    value_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = heap_apply(kind, key);
    expected_results.push_back(typed ? want : predicted);
    commands_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic void check_field(input string name, input logic [KEY_W-1:0] got,
                                      input logic [KEY_W-1:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    end
  endfunction

  // Result side: random backpressure, except in the calm window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Compare every result transaction against the oldest owed result, and
  // end the run if neither channel moves for too long.
  always @(posedge clk_i) begin : result_check
    heap_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result with nothing outstanding, status %0d count %0d",
                     $time, status_o, entry_count_o);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("status", KEY_W'(status_o), KEY_W'(want.status));
          check_field("removed_value", removed_value_o, want.removed);
          check_field("top_valid", KEY_W'(top_valid_o), KEY_W'(want.top_valid));
          check_field("top_value", top_value_o, want.top);
          check_field("entry_count", KEY_W'(entry_count_o), KEY_W'(want.entries));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_max_heap_priority_queue: errors");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int   random_count;
    mix_e mix;
    int   burst_len;
    logic [1:0] kind;
    random_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      push_command(directed_rows[i].kind, directed_rows[i].key,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // Fill past capacity so the last inserts are refused, then pause until
    // the block has answered everything, then empty past zero.
    for (int i = 0; i < CAPACITY + 6; i++) begin
      push_command(KIND_INSERT, pick_key(), 1'b0, NO_CHECK);
    end
    wait_for_drain();
    for (int i = 0; i < CAPACITY + 6; i++) begin
      push_command(KIND_REMOVE, pick_key(), 1'b0, NO_CHECK);
    end

    // Bursts that lean toward filling, draining or holding the size steady,
    // with occasional clears and no-op codes mixed in.
    while (random_count < RANDOM_ITEMS) begin
      mix = mix_e'($urandom_range(2));
      burst_len = $urandom_range(20, 120);
      if ($urandom_range(3) == 0) begin
        wait_for_drain();
      end
      for (int i = 0; i < burst_len; i++) begin
        kind = pick_kind(mix);
        push_command(kind, pick_key(), 1'b0, NO_CHECK);
        if (kind != KIND_SPARE) begin
          random_count++;
        end
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_max_heap_priority_queue: clean");
    end else begin
      $display("tb_max_heap_priority_queue: errors");
    end
    $finish;
  end

endmodule
